// ===== rtl/rvbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rvbd_pkg
// Types and constants shared by the run-length / varint byte decoder.
// ----------------------------------------------------------------------------
package rvbd_pkg;

  localparam int MAX_LENGTH_GROUPS = 3;
  localparam int HW_GROUP_LIMIT    = 3;
  localparam int GROUP_LIMIT       = (MAX_LENGTH_GROUPS < HW_GROUP_LIMIT) ?
                                     MAX_LENGTH_GROUPS : HW_GROUP_LIMIT;
  localparam int GROUP_BITS        = 7;
  localparam int LEN_W             = 21;
  localparam int GIDX_W            = 2;

  localparam logic [7:0]        TAG_BYTE   = 8'h80;
  localparam logic [7:0]        GROUP_MASK = 8'h7F;
  localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
  localparam logic [GIDX_W-1:0] GIDX_LIMIT = GIDX_W'(GROUP_LIMIT);
  localparam logic [GIDX_W-1:0] GIDX_MAX   = GIDX_W'(HW_GROUP_LIMIT);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVF   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_OPEN = 2'd1,
    KIND_LEN  = 2'd2
  } kind_t;

  typedef enum logic {
    FE_LITERAL = 1'b0,
    FE_TAG     = 1'b1
  } fe_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    kind_t      kind;
    logic [7:0] rep;
  } entry_t;

endpackage

// ===== rtl/rvbd_front.sv =====
// ----------------------------------------------------------------------------
// rvbd_front
// Accepts raw bytes, tracks literal/tag mode and tags each byte with its kind.
// ----------------------------------------------------------------------------
module rvbd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            fifo_full,
  output logic            push,
  output rvbd_pkg::entry_t push_entry
);
  import rvbd_pkg::*;

  fe_state_t  state_r, state_nxt;
  logic [7:0] prev_r, prev_nxt;

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_LITERAL: begin
        if (push && in_tdata == TAG_BYTE && !in_tlast) state_nxt = FE_TAG;
      end
      FE_TAG: begin
        if (push && (in_tdata[7] || in_tlast)) state_nxt = FE_LITERAL;
      end
      default: state_nxt = FE_LITERAL;
    endcase
  end

  always_comb begin
    push_entry.data = in_tdata;
    push_entry.eoi  = in_tlast;
    push_entry.rep  = prev_r;
    case (state_r)
      FE_LITERAL: push_entry.kind = (in_tdata == TAG_BYTE) ? KIND_OPEN : KIND_LIT;
      FE_TAG:     push_entry.kind = KIND_LEN;
      default:    push_entry.kind = KIND_LIT;
    endcase
  end

  always_comb begin
    prev_nxt = prev_r;
    if (push) prev_nxt = in_tlast ? 8'h00 : in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_LITERAL;
      prev_r  <= 8'h00;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ===== rtl/rvbd_fifo.sv =====
// ----------------------------------------------------------------------------
// rvbd_fifo
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module rvbd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rvbd_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output rvbd_pkg::entry_t head
);
  import rvbd_pkg::*;

  entry_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/rvbd_back.sv =====
// ----------------------------------------------------------------------------
// rvbd_back
// Length accumulation and run descriptor generation, registered output.
// ----------------------------------------------------------------------------
module rvbd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  rvbd_pkg::entry_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import rvbd_pkg::*;

  logic [GIDX_W-1:0] gi_r, gi_nxt;
  len_t              acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [7:0]        rep_r, rep_nxt;

  logic              vld_r, vld_nxt;
  logic [7:0]        val_r, val_nxt;
  len_t              cnt_r, cnt_nxt;
  status_t           st_r, st_nxt;
  logic              last_r, last_nxt;

  logic [7:0]        payload;
  len_t              len;
  logic              has_res;
  logic [7:0]        res_val;
  len_t              res_cnt;
  status_t           res_st;

  assign pop     = !empty && (!vld_r || out_tready);
  assign payload = head.data & GROUP_MASK;

  always_comb begin
    gi_nxt  = gi_r;
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    rep_nxt = rep_r;
    has_res = 1'b0;
    res_val = 8'h00;
    res_cnt = '0;
    res_st  = ST_OK;
    len     = '0;
    case (head.kind)
      KIND_LIT: begin
        has_res = 1'b1;
        res_val = head.data;
        res_cnt = len_t'(1);
      end
      KIND_OPEN: begin
        rep_nxt = head.rep;
        gi_nxt  = '0;
        acc_nxt = '0;
        ovf_nxt = 1'b0;
        if (head.eoi) begin
          has_res = 1'b1;
          res_st  = ST_TRUNC;
        end
      end
      KIND_LEN: begin
        if (gi_r < GIDX_LIMIT) begin
          acc_nxt = acc_r | (len_t'(payload) << (GROUP_BITS * int'(gi_r)));
        end else if (payload != 8'h00) begin
          ovf_nxt = 1'b1;
        end
        if (gi_r != GIDX_MAX) gi_nxt = gi_r + 1'b1;
        len = ovf_nxt ? LEN_MAX : acc_nxt;
        if (head.data[7]) begin
          has_res = 1'b1;
          if (len == '0) begin
            res_val = TAG_BYTE;
            res_cnt = len_t'(1);
          end else begin
            res_val = rep_r;
            res_cnt = (len == len_t'(1)) ? len_t'(1) : len - 1'b1;
            res_st  = ovf_nxt ? ST_OVF : ST_OK;
          end
        end else if (head.eoi) begin
          has_res = 1'b1;
          res_st  = ST_TRUNC;
        end
      end
      default: ;
    endcase
    if (head.eoi) begin
      gi_nxt  = '0;
      acc_nxt = '0;
      ovf_nxt = 1'b0;
      rep_nxt = 8'h00;
    end
  end

  always_comb begin
    vld_nxt  = vld_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    st_nxt   = st_r;
    last_nxt = last_r;
    if (out_tready) vld_nxt = 1'b0;
    if (pop && has_res) begin
      vld_nxt  = 1'b1;
      val_nxt  = res_val;
      cnt_nxt  = res_cnt;
      st_nxt   = res_st;
      last_nxt = head.eoi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gi_r  <= '0;
      acc_r <= '0;
      ovf_r <= 1'b0;
      rep_r <= 8'h00;
      vld_r <= 1'b0;
    end else begin
      if (pop) begin
        gi_r  <= gi_nxt;
        acc_r <= acc_nxt;
        ovf_r <= ovf_nxt;
        rep_r <= rep_nxt;
      end
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'b000, cnt_r, val_r};
  assign out_tuser  = st_r;
  assign out_tlast  = last_r;

  a_trunc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && st_r == ST_TRUNC |-> last_r && cnt_r == '0 && val_r == 8'h00)
    else $error("truncation result malformed");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && (st_r == ST_OK || st_r == ST_OVF) |-> cnt_r != '0)
    else $error("zero count on good result");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.eoi |=> gi_r == '0 && acc_r == '0 && !ovf_r && rep_r == 8'h00)
    else $error("state not cleared after end of stream");

endmodule

// ===== rtl/rle_varint_byte_decoder_top.sv =====
// ----------------------------------------------------------------------------
// rle_varint_byte_decoder_top
// Run-length decoder with varint run lengths; one run descriptor per item.
//
//   channel | dir | tdata                               | tuser     | tlast
//   in_     | in  | [7:0] data_byte                     | -         | end_of_input
//   out_    | out | [7:0] run_value, [28:8] run_count   | [1:0] status | final_result
//
// One byte per cycle sustained while the output is not stalled.
// The front tags each byte, a two-entry queue decouples it from the back,
// which updates the length state and loads the output register.
// Synchronous active-low reset clears mode, queue and length state.
// A stalled output holds; the queue absorbs two bytes before in_tready drops.
// ----------------------------------------------------------------------------
module rle_varint_byte_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] run_value, [28:8] run_count, [31:29] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);
  import rvbd_pkg::*;

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_entry;
  entry_t head;

  rvbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .fifo_full  (full),
    .push       (push),
    .push_entry (push_entry)
  );

  rvbd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  rvbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/tb_rle_varint_byte_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_varint_byte_decoder_top
// Streams raw bytes into the run-length / varint decoder. A local decoder
// predicts each run descriptor, and the monitor compares every output
// transaction field by field. Phases vary source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_rle_varint_byte_decoder_top;
  import rvbd_pkg::*;

  localparam int PHASE_BYTES = 245;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] data;
    logic       eoi;
    logic       hold;   // wait for all outstanding runs before sending
  } raw_byte_t;

  typedef struct {
    logic [7:0] value;
    len_t       count;
    status_t    status;
    logic       fin;
  } run_desc_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [7:0] run_value, [28:8] run_count, [31:29] zero
  logic [1:0]  out_tuser;          // [1:0] status
  logic        out_tlast;

  raw_byte_t byte_q[$];
  run_desc_t run_q[$];
  raw_byte_t cur_byte;
  run_desc_t got_run;
  int        errors = 0;
  int        idle_cycles = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;

  // decoder state mirror
  logic       tag_mode = 1'b0;
  logic [1:0] grp_cnt = 2'd0;
  len_t       len_acc = '0;
  logic       ovf = 1'b0;
  logic [7:0] last_byte = 8'h00;
  logic [7:0] rep_byte = 8'h00;

  rle_varint_byte_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic void decode_byte(input logic [7:0] b, input logic eoi);
    logic [6:0] payload;
    len_t       run_len;
    run_desc_t  trunc_run;
    payload = b[6:0];
    trunc_run = '{8'h00, len_t'(0), ST_TRUNC, 1'b1};
    if (!tag_mode) begin
      if (b == TAG_BYTE) begin
        rep_byte = last_byte;
        tag_mode = 1'b1;
        grp_cnt = 2'd0;
        len_acc = '0;
        ovf = 1'b0;
        if (eoi) run_q.insert(run_q.size(), trunc_run);
      end else begin
        run_q.insert(run_q.size(), run_desc_t'{b, len_t'(1), ST_OK, eoi});
      end
    end else begin
      if (grp_cnt < GROUP_LIMIT)
        len_acc = len_acc | (len_t'(payload) << (GROUP_BITS * grp_cnt));
      else if (payload != 7'd0)
        ovf = 1'b1;
      if (grp_cnt < HW_GROUP_LIMIT) grp_cnt = grp_cnt + 2'd1;
      if (b[7]) begin
        run_len = ovf ? LEN_MAX : len_acc;
        tag_mode = 1'b0;
        if (run_len == '0)
          run_q.insert(run_q.size(), run_desc_t'{TAG_BYTE, len_t'(1), ST_OK, eoi});
        else
          run_q.insert(run_q.size(),
                       run_desc_t'{rep_byte,
                                   (run_len == len_t'(1)) ? run_len : run_len - len_t'(1),
                                   ovf ? ST_OVF : ST_OK, eoi});
      end else if (eoi) begin
        run_q.insert(run_q.size(), trunc_run);
      end
    end
    last_byte = b;
    if (eoi) begin
      tag_mode = 1'b0;
      grp_cnt = 2'd0;
      len_acc = '0;
      ovf = 1'b0;
      last_byte = 8'h00;
      rep_byte = 8'h00;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic eoi,
                                    input logic hold = 1'b0);
    raw_byte_t it;
    it.data = b;
    it.eoi = eoi;
    it.hold = hold;
    byte_q.insert(byte_q.size(), it);
  endfunction

  // mostly well-formed tags with random payloads, plus literals and noise
  function automatic void add_random_bytes(input int count);
    int         added;
    int         pick;
    int         ngrp;
    int         cut;
    logic [7:0] b;
    logic [6:0] payload;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        do b = 8'($urandom); while (b == TAG_BYTE);
        push_byte(b, $urandom_range(49) == 0);
        added++;
      end else if (pick < 90) begin
        pick = $urandom_range(99);
        ngrp = (pick < 50) ? 1 : (pick < 75) ? 2 : (pick < 88) ? 3 : $urandom_range(4, 6);
        cut = ($urandom_range(19) == 0) ? $urandom_range(0, ngrp - 1) : ngrp + 1;
        push_byte(TAG_BYTE, cut == 0, $urandom_range(39) == 0);
        added++;
        for (int i = 1; i <= ngrp && cut != 0; i++) begin
          pick = $urandom_range(7);
          payload = (pick < 2) ? 7'h00 : (pick == 2) ? 7'h7F : 7'($urandom);
          if (i == cut) begin
            push_byte({1'b0, payload}, 1'b1);
            added++;
            break;
          end
          if (i == ngrp)
            push_byte({1'b1, payload}, $urandom_range(29) == 0);
          else
            push_byte({1'b0, payload}, 1'b0);
          added++;
        end
      end else begin
        push_byte(8'($urandom), $urandom_range(19) == 0);
        added++;
      end
    end
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  // byte source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) decode_byte(cur_byte.data, cur_byte.eoi);
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && !(byte_q[0].hold && run_q.size() != 0) &&
            $urandom_range(99) >= src_idle_pct) begin
          cur_byte = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur_byte.data;
          in_tlast <= cur_byte.eoi;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // run descriptor monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (run_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual data 0x%0h user 0x%0h",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          got_run = run_q.pop_front();
          check_field("run_value", 32'(got_run.value), 32'(out_tdata[7:0]));
          check_field("run_count", 32'(got_run.count), 32'(out_tdata[28:8]));
          check_field("tdata pad", 32'd0, 32'(out_tdata[31:29]));
          check_field("status", 32'(got_run.status), 32'(out_tuser));
          check_field("final_result", 32'(got_run.fin), 32'(out_tlast));
        end
      end
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // opener as the very first byte repeats zero
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h83, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // escape
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h80, 1'b0);
    // length one, repeats the previous tag's length byte
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h81, 1'b0);
    // full 21-bit length
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h7F, 1'b0); push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    // extra nonzero group saturates
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h81, 1'b0);
    // extra zero groups are dropped
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h05, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
    // end of stream on closing byte, on opener, inside length
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h83, 1'b1);
    push_byte(TAG_BYTE, 1'b1);
    push_byte(TAG_BYTE, 1'b0); push_byte(8'h05, 1'b1);
    push_byte(8'h2A, 1'b1, 1'b1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      add_random_bytes(PHASE_BYTES);
      while (byte_q.size() != 0) @(negedge clk);
    end

    while (in_tvalid) @(negedge clk);
    while (run_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
